@@ design/periodic_task_ready_scheduler_macros.svh @@
// assertion macros for the periodic task ready scheduler
`ifndef PERIODIC_TASK_READY_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_READY_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define PRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off while rst_n is low
`define PRTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRTS_ASSERT_NOW(lbl, ante, cons, msg)
`define PRTS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/prts_pkg.sv @@
// shared types and constants for the periodic task ready scheduler
package prts_pkg;

  localparam int MAX_TASKS     = 8;
  localparam int NUM_TASKS_DEF = 8;

  localparam int CNT_W   = 8;
  localparam int PHASE_W = 4;
  localparam int OFF_W   = 4;
  localparam int PER_W   = 8;

  localparam logic [PHASE_W-1:0] LAST_START_PHASE = 4'd8;
  localparam logic [CNT_W-1:0]   COUNT_MAX        = 8'hFF;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 2;

  // register indexes, byte address is 8 * index
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSETS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CNT_CLR_MASK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RDY_CLR_MASK  = 2'd3;

  localparam logic [31:0]        START_OFFSETS_RST = 32'h8765_4320;
  localparam logic [63:0]        PERIODS_RST       = 64'h0A0A_0A02_020A_0A0A;
  localparam logic [MAX_TASKS-1:0] CNT_CLR_MASK_RST  = 8'hFE;
  localparam logic [MAX_TASKS-1:0] RDY_CLR_MASK_RST  = 8'hDF;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_SERVICE = 1'b1;

  typedef struct packed {
    logic [OFF_W*MAX_TASKS-1:0] start_offsets;
    logic [PER_W*MAX_TASKS-1:0] periods;
    logic [MAX_TASKS-1:0]       counter_clear_mask;
    logic [MAX_TASKS-1:0]       ready_clear_mask;
  } prts_cfg_t;

endpackage

@@ design/periodic_task_ready_scheduler.sv @@
// top level of the periodic task ready scheduler
// result: the result of each accepted beat is registered and then shown on out_tvalid and out_tdata
// throughput: one input beat per cycle while out_tready is high; a result held by
// out_tready low stalls in_tready for every cycle of the hold
// reset (rst_n low, synchronous): phase, started, counters and ready flags cleared,
// config registers back to their reset values, output channel empty
`include "periodic_task_ready_scheduler_macros.svh"

module periodic_task_ready_scheduler
  import prts_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] service_mask
  input  logic                  in_tuser,   // [0] kind
  // result beats
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [7:0] ready_mask, [15:8] started_mask
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  prts_cfg_t cfg;

  prts_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // scheduler state
  logic [PHASE_W-1:0]   start_phase_r, start_phase_nxt;
  logic [NUM_TASKS-1:0] started_r, started_nxt;
  logic [NUM_TASKS-1:0] ready_r, ready_nxt;
  logic [CNT_W-1:0]     cnt_r   [NUM_TASKS];
  logic [CNT_W-1:0]     cnt_nxt [NUM_TASKS];

  // output register
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic [15:0] out_data_nxt;

  logic                 in_acc;
  logic                 is_tick;
  logic                 phase_live;
  logic [NUM_TASKS-1:0] hit;
  logic [MAX_TASKS-1:0] ready8, started8;

  // a waiting result does not stop intake as long as it leaves this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign is_tick   = (in_tuser == KIND_TICK);

  // start phases run 0..8, then the phase parks at 9
  assign phase_live = (start_phase_r <= LAST_START_PHASE);

  always_comb begin
    start_phase_nxt = start_phase_r;
    started_nxt     = started_r;
    ready_nxt       = ready_r;
    hit             = in_tdata[NUM_TASKS-1:0] & ready_r;
    for (int t = 0; t < NUM_TASKS; t++) begin
      cnt_nxt[t] = cnt_r[t];
    end
    if (is_tick) begin
      if (phase_live) begin
        for (int t = 0; t < NUM_TASKS; t++) begin
          // offsets 9..15 can never match a live phase
          if (cfg.start_offsets[OFF_W*t +: OFF_W] == start_phase_r) begin
            started_nxt[t] = 1'b1;
          end
        end
        start_phase_nxt = start_phase_r + 1'b1;
      end
      for (int t = 0; t < NUM_TASKS; t++) begin
        // a task started on this tick already counts it
        if (started_nxt[t] && (cnt_r[t] != COUNT_MAX)) begin
          cnt_nxt[t] = cnt_r[t] + 1'b1;
        end
        // zero period sets ready even before the task starts
        if (cnt_nxt[t] >= cfg.periods[PER_W*t +: PER_W]) begin
          ready_nxt[t] = 1'b1;
        end
      end
    end else begin
      // service only acts on tasks that are ready
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (hit[t] && cfg.counter_clear_mask[t]) begin
          cnt_nxt[t] = '0;
        end
      end
      ready_nxt = ready_r & ~(hit & cfg.ready_clear_mask[NUM_TASKS-1:0]);
    end
  end

  // tasks beyond NUM_TASKS read as zero
  always_comb begin
    ready8                  = '0;
    started8                = '0;
    ready8[NUM_TASKS-1:0]   = ready_nxt;
    started8[NUM_TASKS-1:0] = started_nxt;
    out_data_nxt            = {started8, ready8};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_phase_r <= '0;
      started_r     <= '0;
      ready_r       <= '0;
      for (int t = 0; t < NUM_TASKS; t++) begin
        cnt_r[t] <= '0;
      end
    end else if (in_acc) begin
      start_phase_r <= start_phase_nxt;
      started_r     <= started_nxt;
      ready_r       <= ready_nxt;
      for (int t = 0; t < NUM_TASKS; t++) begin
        cnt_r[t] <= cnt_nxt[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PRTS_ASSERT_NOW(a_phase_range, 1'b1, start_phase_r <= (LAST_START_PHASE + 1'b1), "start phase ran past its parking value")
  `PRTS_ASSERT_NXT(a_acc_gives_result, in_acc, out_valid_r, "accepted beat left no result")
  `PRTS_ASSERT_NXT(a_service_keeps_start, in_acc && (in_tuser == KIND_SERVICE), $stable(started_r) && $stable(start_phase_r), "service beat changed start state")
  `PRTS_ASSERT_NXT(a_phase_step, in_acc && (in_tuser == KIND_TICK) && phase_live, start_phase_r == ($past(start_phase_r) + 1'b1), "live phase did not advance on tick")

endmodule

@@ design/prts_cfg_regs.sv @@
// configuration register bank with apb-style access
module prts_cfg_regs
  import prts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output prts_cfg_t             cfg
);

  prts_cfg_t cfg_r;
  logic [CFG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx        = cfg_paddr[CFG_ADDR_W-1 -: CFG_IDX_W];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_offsets      <= START_OFFSETS_RST;
      cfg_r.periods            <= PERIODS_RST;
      cfg_r.counter_clear_mask <= CNT_CLR_MASK_RST;
      cfg_r.ready_clear_mask   <= RDY_CLR_MASK_RST;
    end else if (wr_en) begin
      case (idx)
        REG_START_OFFSETS: cfg_r.start_offsets      <= cfg_pwdata[OFF_W*MAX_TASKS-1:0];
        REG_PERIODS:       cfg_r.periods            <= cfg_pwdata[PER_W*MAX_TASKS-1:0];
        REG_CNT_CLR_MASK:  cfg_r.counter_clear_mask <= cfg_pwdata[MAX_TASKS-1:0];
        REG_RDY_CLR_MASK:  cfg_r.ready_clear_mask   <= cfg_pwdata[MAX_TASKS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (idx)
      REG_START_OFFSETS: cfg_prdata[OFF_W*MAX_TASKS-1:0] = cfg_r.start_offsets;
      REG_PERIODS:       cfg_prdata[PER_W*MAX_TASKS-1:0] = cfg_r.periods;
      REG_CNT_CLR_MASK:  cfg_prdata[MAX_TASKS-1:0]       = cfg_r.counter_clear_mask;
      REG_RDY_CLR_MASK:  cfg_prdata[MAX_TASKS-1:0]       = cfg_r.ready_clear_mask;
      default:           cfg_prdata = '0;
    endcase
  end

endmodule
